FILE: rtl/core/cdac_pkg.sv
// Shared constants, register indexes and divider handshake types for the cross-fade block.
`default_nettype none

package cdac_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned CH_IDX_W  = $clog2(NUM_CH);
  localparam int unsigned DUR_W     = 32;
  localparam int unsigned TICK_W    = 64;
  localparam int unsigned PIX_W     = 32;
  localparam int unsigned DIV_W     = DUR_W + CH_W;
  localparam int unsigned CNT_W     = $clog2(DIV_W + 1);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [DUR_W-1:0] MIN_DURATION = DUR_W'(2);
  localparam logic [CH_W-1:0]  CH_MAX       = {CH_W{1'b1}};

  localparam logic [CH_IDX_W-1:0] CH_A = CH_IDX_W'(0);
  localparam logic [CH_IDX_W-1:0] CH_R = CH_IDX_W'(1);
  localparam logic [CH_IDX_W-1:0] CH_G = CH_IDX_W'(2);
  localparam logic [CH_IDX_W-1:0] CH_B = CH_IDX_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION    = 3'd0,
    CFG_DELAY_RED   = 3'd1,
    CFG_DELAY_GREEN = 3'd2,
    CFG_DELAY_BLUE  = 3'd3,
    CFG_DELAY_ALPHA = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DUR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/channel_delayed_argb_crossfade_top.sv
// Top level of the per-channel delayed ARGB cross-fade block.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | op_i, tick_i, src1_pixel_i, src2_pixel_i
//   out     | output    | out_valid_o/out_ready_i| result_pixel_o, transition_done_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A pixel request's result sits in the output register in the cycle after acceptance.
// A frame request runs five divisions by 255, one for the span and one delay time per channel,
// each folding high bytes into the low byte; each channel past its delay then also divides
// in the shared 40-bit divider, and the frame result is registered once all channels are done.
// Reset clears the sequencer and output valid; no clearing pass is needed.
// A stalled output holds its result, and no new request is taken until it is free.
`default_nettype none

module channel_delayed_argb_crossfade_top (
  input  wire  logic                           clk_i,
  input  wire  logic                           rst_ni,
  input  wire  logic                           in_valid_i,
  output logic                                 in_ready_o,
  input  wire  logic                           op_i,
  input  wire  logic [cdac_pkg::TICK_W-1:0]    tick_i,
  input  wire  logic [cdac_pkg::PIX_W-1:0]     src1_pixel_i,
  input  wire  logic [cdac_pkg::PIX_W-1:0]     src2_pixel_i,
  output logic                                 out_valid_o,
  input  wire  logic                           out_ready_i,
  output logic [cdac_pkg::PIX_W-1:0]           result_pixel_o,
  output logic                                 transition_done_o,
  input  wire  logic                           cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  logic [cdac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  logic [cdac_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import cdac_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAN_ISSUE,
    ST_SPAN_WAIT,
    ST_DLY_ISSUE,
    ST_DLY_WAIT,
    ST_OPA_ISSUE,
    ST_OPA_WAIT,
    ST_FINISH
  } state_e;

  state_e                state_q;
  logic [DUR_W-1:0]      duration_q;
  logic [CH_W-1:0]       delay_q [NUM_CH];
  logic [CH_W-1:0]       opa_q [NUM_CH];
  logic                  first_q;
  logic [TICK_W-1:0]     start_time_q;
  logic [DUR_W-1:0]      elapsed_q;
  logic [DUR_W-1:0]      span_q;
  logic [DUR_W-1:0]      dtime_q;
  logic [CH_IDX_W-1:0]   ch_q;
  logic [DIV_W-1:0]      div_a_q;
  logic [DUR_W-1:0]      div_b_q;
  logic                  div_go_q;
  logic [DIV_W-1:0]      fold_q;
  logic [DUR_W-1:0]      acc_q;
  logic [PIX_W-1:0]      result_pixel_q;
  logic                  transition_done_q;
  logic                  out_valid_q;

  logic [DUR_W-1:0]      t_eff;
  logic [CH_W-1:0]       max_delay;
  logic [CH_W-1:0]       mul_fac;
  logic [DIV_W-1:0]      mul_prod;
  logic [DUR_W-1:0]      opa_diff;
  logic [DIV_W-1:0]      opa_dividend;
  logic [CH_W-1:0]       opa_clamped;
  logic [DUR_W-1:0]      fold_hi;
  logic [DIV_W-1:0]      fold_next;
  logic                  fold_done;
  logic [DUR_W-1:0]      fold_quo;
  logic [TICK_W-1:0]     start_sel;
  logic [TICK_W-1:0]     tick_diff;
  logic [DUR_W-1:0]      elapsed_new;
  logic                  out_free;
  logic                  out_load;
  logic                  in_acc;

  logic [CH_W-1:0]         v1 [NUM_CH];
  logic [CH_W-1:0]         v2 [NUM_CH];
  logic signed [CH_W:0]    diff_s [NUM_CH];
  logic signed [2*CH_W+1:0] prod_s [NUM_CH];
  logic [2*CH_W-1:0]       prod_u [NUM_CH];
  logic [2*CH_W-1:0]       a2_prod;
  logic [CH_W-1:0]         blend_ch [NUM_CH];
  logic [PIX_W-1:0]        blend_pix;
  logic [PIX_W-1:0]        pix_res;
  logic                    degenerate;

  cdac_pkg::div_req_t div_req;
  cdac_pkg::div_rsp_t div_rsp;

  cdac_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign div_req.start    = div_go_q;
  assign div_req.dividend = div_a_q;
  assign div_req.divisor  = div_b_q;

  assign t_eff    = (duration_q < MIN_DURATION) ? MIN_DURATION : duration_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_load = ((state_q == ST_IDLE) && in_acc && op_i) ||
                    ((state_q == ST_FINISH) && out_free);

  always_comb begin
    max_delay = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (delay_q[c] > max_delay) begin
        max_delay = delay_q[c];
      end
    end
  end

  assign mul_fac      = (state_q == ST_SPAN_ISSUE) ? (CH_MAX - max_delay) : delay_q[ch_q];
  assign mul_prod     = mul_fac * t_eff;
  assign opa_diff     = elapsed_q - dtime_q;
  assign opa_dividend = {opa_diff, {CH_W{1'b0}}} - DIV_W'(opa_diff);
  assign opa_clamped  = (|div_rsp.quotient[DIV_W-1:CH_W]) ? CH_MAX
                                                          : div_rsp.quotient[CH_W-1:0];

  // Since 256 is one more than 255, x = 256*h + l gives x / 255 = h + (h + l) / 255.
  assign fold_hi   = fold_q[DIV_W-1:CH_W];
  assign fold_next = DIV_W'(fold_hi) + DIV_W'(fold_q[CH_W-1:0]);
  assign fold_done = (fold_hi == '0);
  assign fold_quo  = acc_q + DUR_W'(fold_q[CH_W-1:0] == CH_MAX);

  assign start_sel   = first_q ? tick_i : start_time_q;
  assign tick_diff   = tick_i - start_sel;
  assign elapsed_new = (tick_diff > TICK_W'(t_eff)) ? t_eff : tick_diff[DUR_W-1:0];

  always_comb begin
    degenerate = 1'b0;
    blend_pix  = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      v1[c]     = src1_pixel_i[PIX_W-CH_W*(c+1) +: CH_W];
      v2[c]     = src2_pixel_i[PIX_W-CH_W*(c+1) +: CH_W];
      diff_s[c] = $signed({1'b0, v2[c]}) - $signed({1'b0, v1[c]});
      prod_s[c] = diff_s[c] * $signed({1'b0, opa_q[c]});
      prod_u[c] = v1[c] * opa_q[c];
    end
    a2_prod    = v2[CH_A] * opa_q[CH_A];
    degenerate = (v1[CH_A] == '0) || (v2[CH_A] == '0);
    for (int c = 0; c < NUM_CH; c++) begin
      if (degenerate) begin
        blend_ch[c] = prod_u[c][CH_W-1:0];
      end else begin
        blend_ch[c] = v1[c] + prod_s[c][2*CH_W-1:CH_W];
      end
    end
    if (degenerate) begin
      if (v2[CH_A] == '0) begin
        blend_ch[CH_A] = v1[CH_A] - prod_u[CH_A][2*CH_W-1:CH_W];
      end else begin
        blend_ch[CH_A] = a2_prod[2*CH_W-1:CH_W];
      end
    end
    for (int c = 0; c < NUM_CH; c++) begin
      blend_pix[PIX_W-CH_W*(c+1) +: CH_W] = blend_ch[c];
    end
  end

  always_comb begin
    if (elapsed_q == '0) begin
      pix_res = src1_pixel_i;
    end else if (elapsed_q == t_eff) begin
      pix_res = src2_pixel_i;
    end else begin
      pix_res = blend_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      duration_q        <= MIN_DURATION;
      for (int c = 0; c < NUM_CH; c++) begin
        delay_q[c] <= '0;
        opa_q[c]   <= '0;
      end
      first_q           <= 1'b1;
      start_time_q      <= '0;
      elapsed_q         <= '0;
      span_q            <= DUR_W'(1);
      dtime_q           <= '0;
      ch_q              <= '0;
      div_a_q           <= '0;
      div_b_q           <= '0;
      div_go_q          <= 1'b0;
      fold_q            <= '0;
      acc_q             <= '0;
      result_pixel_q    <= '0;
      transition_done_q <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      div_go_q <= (state_q == ST_OPA_ISSUE) && (elapsed_q > dtime_q);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_DURATION:    duration_q    <= cfg_data_i[DUR_W-1:0];
          CFG_DELAY_RED:   delay_q[CH_R] <= cfg_data_i[CH_W-1:0];
          CFG_DELAY_GREEN: delay_q[CH_G] <= cfg_data_i[CH_W-1:0];
          CFG_DELAY_BLUE:  delay_q[CH_B] <= cfg_data_i[CH_W-1:0];
          CFG_DELAY_ALPHA: delay_q[CH_A] <= cfg_data_i[CH_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (op_i) begin
              result_pixel_q    <= pix_res;
              transition_done_q <= 1'b0;
            end else begin
              first_q   <= 1'b0;
              if (first_q) begin
                start_time_q <= tick_i;
              end
              elapsed_q <= elapsed_new;
              state_q   <= ST_SPAN_ISSUE;
            end
          end
        end
        ST_SPAN_ISSUE: begin
          fold_q  <= mul_prod;
          acc_q   <= '0;
          state_q <= ST_SPAN_WAIT;
        end
        ST_SPAN_WAIT: begin
          if (fold_done) begin
            span_q  <= (fold_quo == '0) ? DUR_W'(1) : fold_quo;
            ch_q    <= '0;
            state_q <= ST_DLY_ISSUE;
          end else begin
            acc_q  <= acc_q + fold_hi;
            fold_q <= fold_next;
          end
        end
        ST_DLY_ISSUE: begin
          fold_q  <= mul_prod;
          acc_q   <= '0;
          state_q <= ST_DLY_WAIT;
        end
        ST_DLY_WAIT: begin
          if (fold_done) begin
            dtime_q <= fold_quo;
            state_q <= ST_OPA_ISSUE;
          end else begin
            acc_q  <= acc_q + fold_hi;
            fold_q <= fold_next;
          end
        end
        ST_OPA_ISSUE: begin
          if (elapsed_q > dtime_q) begin
            div_a_q  <= opa_dividend;
            div_b_q  <= span_q;
            state_q  <= ST_OPA_WAIT;
          end else begin
            opa_q[ch_q] <= '0;
            if (ch_q == CH_IDX_W'(NUM_CH - 1)) begin
              state_q <= ST_FINISH;
            end else begin
              ch_q    <= ch_q + CH_IDX_W'(1);
              state_q <= ST_DLY_ISSUE;
            end
          end
        end
        ST_OPA_WAIT: begin
          if (div_rsp.done) begin
            opa_q[ch_q] <= opa_clamped;
            if (ch_q == CH_IDX_W'(NUM_CH - 1)) begin
              state_q <= ST_FINISH;
            end else begin
              ch_q    <= ch_q + CH_IDX_W'(1);
              state_q <= ST_DLY_ISSUE;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            result_pixel_q    <= '0;
            transition_done_q <= (elapsed_q == t_eff);
            state_q           <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE) && out_free;
  assign out_valid_o       = out_valid_q;
  assign result_pixel_o    = result_pixel_q;
  assign transition_done_o = transition_done_q;
  assign cfg_ready_o       = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/core/cdac_div.sv
// Shared restoring divider that produces one quotient bit per cycle.
`default_nettype none

module cdac_div (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                cdac_pkg::div_req_t req_i,
  output cdac_pkg::div_rsp_t rsp_o
);
  import cdac_pkg::*;

  logic [DUR_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DUR_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DUR_W:0]   trial;
  logic             fits;

  always_comb begin
    trial  = {rem_q, quo_q[DIV_W-1]};
    fits   = (trial >= {1'b0, dvs_q});
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      cnt_d  = CNT_W'(DIV_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DUR_W'(trial - {1'b0, dvs_q}) : trial[DUR_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (req_i.start) begin
      dvs_q <= req_i.divisor;
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/cdac_checker.sv
// Port-level checks for the cross-fade block and the bind that attaches them.
`default_nettype none

module cdac_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_ready_o,
  input wire logic                       op_i,
  input wire logic                       out_valid_o,
  input wire logic                       out_ready_i,
  input wire logic [cdac_pkg::PIX_W-1:0] result_pixel_o,
  input wire logic                       transition_done_o
);
  import cdac_pkg::*;

  // A frame request keeps the block busy for the following cycle at least.
  a_frame_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !op_i |=> !in_ready_o)
    else $error("input taken right after a frame request");

  // A pixel request produces its result in the next cycle.
  a_pixel_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && op_i |=> out_valid_o && !transition_done_o)
    else $error("pixel result missing or flagged as done");

  // A result flagged as done never carries pixel data.
  a_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && transition_done_o |-> result_pixel_o == '0)
    else $error("frame result carries pixel data");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_pixel_o)
                                    && $stable(transition_done_o))
    else $error("stalled result changed");

endmodule

bind channel_delayed_argb_crossfade_top cdac_checker u_cdac_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .op_i             (op_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .result_pixel_o   (result_pixel_o),
  .transition_done_o(transition_done_o)
);

`default_nettype wire
